[hw/rtl/lcdws_pkg.sv]
package lcdws_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_FOUR_BIT = 2'd0;
    localparam logic [1:0] CFG_SETUP    = 2'd1;
    localparam logic [1:0] CFG_HOLD     = 2'd2;

    // bus level while released for the busy poll
    localparam logic [7:0] BUS_RELEASED = 8'hff;

    // number of fifo entries between front and back
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_POLL,
        PH_SETUP,
        PH_HOLD
    } t_phase;

    typedef enum logic {
        OP_TICK,
        OP_REQ
    } t_op;

    // classified input word
    typedef struct packed {
        t_op        op;
        logic       sel;
        logic [7:0] val;
        logic       busy;
    } t_word;

    typedef struct packed {
        logic       four_bit;
        logic [7:0] setup_ticks;
        logic [7:0] hold_ticks;
    } t_cfg;

    typedef struct packed {
        t_phase     phase;
        logic [7:0] count;
        logic       second;
    } t_seq;

    typedef struct packed {
        logic       rs;
        logic       rw;
        logic       en;
        logic [7:0] bus;
        logic       drive;
        logic       ready_res;
        logic       rejected;
    } t_result;

    // walk through phases whose count already meets the limit
    // (at most setup, hold, setup, hold in one word)
    function automatic t_seq seq_settle(t_seq s, t_cfg c);
        t_seq r;
        r = s;
        for (int k = 0; k < 4; k++) begin
            if (r.phase == PH_SETUP && r.count >= c.setup_ticks) begin
                r.phase = PH_HOLD;
                r.count = '0;
            end else if (r.phase == PH_HOLD && r.count >= c.hold_ticks) begin
                r.count = '0;
                if (c.four_bit && !r.second) begin
                    r.second = 1'b1;
                    r.phase  = PH_SETUP;
                end else begin
                    r.phase = PH_IDLE;
                end
            end
        end
        return r;
    endfunction

endpackage

[hw/rtl/lcdws_front.sv]
module lcdws_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic             i_kind,
    input  logic             i_is_data,
    input  logic [7:0]       i_value,
    input  logic             i_busy_in,
    output logic             o_push,
    output lcdws_pkg::t_word o_word,
    input  logic             i_q_ready
);
    import lcdws_pkg::*;

    logic  r_valid;
    logic  n_valid;
    t_word r_word;
    logic  accept;

    // take a word when the stage is empty or drains this cycle
    assign o_ready = !r_valid || i_q_ready;
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (i_q_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // classify the word: tick or write request
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_word.op   <= i_kind ? OP_REQ : OP_TICK;
            r_word.sel  <= i_is_data;
            r_word.val  <= i_value;
            r_word.busy <= i_busy_in;
        end
    end

    assign o_push = r_valid;
    assign o_word = r_word;

endmodule

[hw/rtl/lcdws_queue.sv]
module lcdws_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  lcdws_pkg::t_word i_word,
    output logic             o_ready,
    output logic             o_valid,
    output lcdws_pkg::t_word o_word,
    input  logic             i_pop
);
    import lcdws_pkg::*;

    localparam int PtrW = $clog2(QUEUE_DEPTH);
    localparam int CntW = $clog2(QUEUE_DEPTH + 1);

    t_word            r_mem [QUEUE_DEPTH];
    logic [PtrW-1:0]  r_wptr;
    logic [PtrW-1:0]  r_rptr;
    logic [CntW-1:0]  r_count;
    logic             do_push;
    logic             do_pop;

    assign o_ready = r_count != CntW'(QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_word  = r_mem[r_rptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_word;
        end
    end

endmodule

[hw/rtl/lcdws_back.sv]
module lcdws_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_idx,
    input  logic [7:0]           i_cfg_data,
    input  logic                 i_q_valid,
    input  lcdws_pkg::t_word     i_word,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_ready,
    output lcdws_pkg::t_result   o_result
);
    import lcdws_pkg::*;

    t_cfg       r_cfg;
    t_phase     r_phase;
    t_phase     n_phase;
    logic [7:0] r_count;
    logic [7:0] n_count;
    logic       r_second;
    logic       n_second;
    logic [7:0] r_byte;
    logic [7:0] n_byte;
    logic       r_sel;
    logic       n_sel;
    logic       r_out_valid;
    t_result    r_out;
    t_result    n_out;
    t_seq       seq_in;
    t_seq       seq_out;
    logic       take;
    logic       rej;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.four_bit    <= 1'b0;
            r_cfg.setup_ticks <= 8'd1;
            r_cfg.hold_ticks  <= 8'd5;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FOUR_BIT: r_cfg.four_bit    <= i_cfg_data[0];
                CFG_SETUP:    r_cfg.setup_ticks <= i_cfg_data;
                CFG_HOLD:     r_cfg.hold_ticks  <= i_cfg_data;
                default:      ;
            endcase
        end
    end

    // one word per cycle whenever the queue holds a word and the result register frees up
    assign take  = i_q_valid && (!r_out_valid || i_ready);
    assign o_pop = take;

    // next sequencer state and result
    always_comb begin
        n_phase  = r_phase;
        n_count  = r_count;
        n_second = r_second;
        n_byte   = r_byte;
        n_sel    = r_sel;
        rej      = 1'b0;
        seq_in   = '{phase: r_phase, count: r_count, second: r_second};

        if (i_word.op == OP_REQ) begin
            if (r_phase == PH_IDLE) begin
                n_byte   = i_word.val;
                n_sel    = i_word.sel;
                n_second = 1'b0;
                n_count  = '0;
                n_phase  = PH_POLL;
            end else begin
                rej = 1'b1;
            end
        end else begin
            unique case (r_phase)
                PH_POLL: begin
                    if (!i_word.busy) begin
                        seq_in.phase = PH_SETUP;
                        seq_in.count = '0;
                    end
                end
                PH_SETUP, PH_HOLD: begin
                    if (r_count != 8'hff) begin
                        seq_in.count = r_count + 8'd1;
                    end
                end
                PH_IDLE: ;
            endcase
        end
        seq_out = seq_settle(seq_in, r_cfg);
        if (i_word.op == OP_TICK) begin
            n_phase  = seq_out.phase;
            n_count  = seq_out.count;
            n_second = seq_out.second;
        end

        // pin levels after this word
        if (n_phase == PH_POLL) begin
            n_out.rs    = 1'b0;
            n_out.rw    = 1'b1;
            n_out.en    = 1'b1;
            n_out.bus   = BUS_RELEASED;
            n_out.drive = 1'b0;
        end else begin
            n_out.rs    = n_sel;
            n_out.rw    = 1'b0;
            n_out.en    = n_phase == PH_HOLD;
            n_out.bus   = n_second ? {n_byte[3:0], 4'h0} : n_byte;
            n_out.drive = 1'b1;
        end
        n_out.ready_res = n_phase == PH_IDLE;
        n_out.rejected  = rej;
    end

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_count  <= '0;
            r_second <= 1'b0;
            r_byte   <= '0;
            r_sel    <= 1'b0;
        end else if (take) begin
            r_phase  <= n_phase;
            r_count  <= n_count;
            r_second <= n_second;
            r_byte   <= n_byte;
            r_sel    <= n_sel;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= n_out;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

[hw/rtl/char_lcd_write_sequencer.sv]
// Character LCD write sequencer for a parallel-bus panel controller.
// Input channel (i_valid/o_ready) carries one word per tick or request:
// i_kind 0 is one time tick, 1 is a write request with i_is_data (RS) and
// i_value. i_busy_in is the panel D7 level sampled on poll ticks.
// Output channel (o_valid/i_ready) returns exactly one word per input word
// with the pin levels after it (RS, RW, E, data bus, drive enable), a ready
// flag when the sequencer is idle and a rejected flag for requests made
// while busy.
// From input accept to result valid a word passes the front register, the
// queue and the result register. Throughput: one word per cycle while the
// receiver does not stall, set by the back end updating its state per word.
// Configuration is written through i_cfg_we/i_cfg_idx/i_cfg_data with the
// block idle; index 0 four-bit mode, 1 setup ticks, 2 hold ticks.
// Reset (synchronous, active low) empties the queue, clears the result
// valid flag, returns to idle with RS 0 and bus 0 driven, and restores the
// register defaults. When the receiver stalls, the result holds, the
// two-entry queue fills and then o_ready drops.
module char_lcd_write_sequencer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_kind,
    input  logic       i_is_data,
    input  logic [7:0] i_value,
    input  logic       i_busy_in,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_rs_out,
    output logic       o_rw_out,
    output logic       o_enable_out,
    output logic [7:0] o_bus_out,
    output logic       o_bus_drive,
    output logic       o_ready_res,
    output logic       o_rejected
);
    import lcdws_pkg::*;

    logic    front_push;
    t_word   front_word;
    logic    q_ready;
    logic    q_valid;
    t_word   q_word;
    logic    q_pop;
    t_result result;

    // accept and classify
    lcdws_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_kind    (i_kind),
        .i_is_data (i_is_data),
        .i_value   (i_value),
        .i_busy_in (i_busy_in),
        .o_push    (front_push),
        .o_word    (front_word),
        .i_q_ready (q_ready)
    );

    // decoupling queue
    lcdws_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_word  (front_word),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_word  (q_word),
        .i_pop   (q_pop)
    );

    // bus sequencer and result register
    lcdws_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_q_valid  (q_valid),
        .i_word     (q_word),
        .o_pop      (q_pop),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_result   (result)
    );

    assign o_rs_out     = result.rs;
    assign o_rw_out     = result.rw;
    assign o_enable_out = result.en;
    assign o_bus_out    = result.bus;
    assign o_bus_drive  = result.drive;
    assign o_ready_res  = result.ready_res;
    assign o_rejected   = result.rejected;

endmodule

[hw/rtl/lcdws_checker.sv]
module lcdws_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_ready,
    input logic       o_rs_out,
    input logic       o_rw_out,
    input logic       o_enable_out,
    input logic [7:0] o_bus_out,
    input logic       o_bus_drive,
    input logic       o_ready_res,
    input logic       o_rejected
);

    // reset leaves no result pending
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_bus_out) && $stable(o_enable_out))
        else $error("stalled result changed");

    // busy poll shows read with released bus and RS low
    a_poll_pins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_rw_out |-> o_enable_out && !o_bus_drive && !o_rs_out
            && o_bus_out == 8'hff && !o_ready_res)
        else $error("bad poll pin levels");

    // a write pulse drives the bus and is never idle
    a_pulse_pins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_enable_out && !o_rw_out |-> o_bus_drive && !o_ready_res)
        else $error("bad write pulse pin levels");

    // rejection only while a write is in progress
    a_reject_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_rejected |-> !o_ready_res)
        else $error("rejected while idle");

endmodule

bind char_lcd_write_sequencer lcdws_checker u_lcdws_checker (.*);

[dv/tb_top.sv]
module tb_top;
    import lcdws_pkg::*;

    localparam int STUCK_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 4;
    localparam int RANDOM_PHASES = 8;
    localparam int WORDS_PER_PHASE = 50;

    // pin levels that can be read straight off the sequencing rules
    localparam t_result PINS_AT_RESET = '{rs: 1'b0, rw: 1'b0, en: 1'b0, bus: 8'h00,
                                          drive: 1'b1, ready_res: 1'b1, rejected: 1'b0};
    localparam t_result PINS_POLLING = '{rs: 1'b0, rw: 1'b1, en: 1'b1, bus: BUS_RELEASED,
                                         drive: 1'b0, ready_res: 1'b0, rejected: 1'b0};
    localparam t_result PINS_POLL_REFUSED = '{rs: 1'b0, rw: 1'b1, en: 1'b1,
                                              bus: BUS_RELEASED, drive: 1'b0,
                                              ready_res: 1'b0, rejected: 1'b1};

    typedef enum logic {
        ROW_WORD,
        ROW_CFG
    } t_row_kind;

    typedef struct {
        t_row_kind  kind;
        t_word      w;
        logic [1:0] idx;
        logic [7:0] data;
        logic       typed;
        t_result    want;
    } t_row;

    logic       i_clk      = 1'b0;
    logic       i_rst_n    = 1'b0;
    logic       i_cfg_we   = 1'b0;
    logic [1:0] i_cfg_idx  = '0;
    logic [7:0] i_cfg_data = '0;
    logic       i_valid    = 1'b0;
    logic       i_kind     = 1'b0;
    logic       i_is_data  = 1'b0;
    logic [7:0] i_value    = '0;
    logic       i_busy_in  = 1'b0;
    logic       i_ready    = 1'b0;
    logic       o_ready;
    logic       o_valid;
    logic       o_rs_out;
    logic       o_rw_out;
    logic       o_enable_out;
    logic [7:0] o_bus_out;
    logic       o_bus_drive;
    logic       o_ready_res;
    logic       o_rejected;

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int mismatch_count = 0;
    int words_checked  = 0;
    int stuck_cycles   = 0;

    t_result pin_levels_q[$];
    t_row    stim_rows[$];

    // predictor state and its copy of the registers
    t_phase     seq_phase   = PH_IDLE;
    logic [7:0] seq_count   = '0;
    logic [7:0] held_byte   = '0;
    logic       held_sel    = 1'b0;
    logic       second_half = 1'b0;
    logic       cfg_four    = 1'b0;
    logic [7:0] cfg_setup   = 8'd1;
    logic [7:0] cfg_hold    = 8'd5;

    char_lcd_write_sequencer dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_kind       (i_kind),
        .i_is_data    (i_is_data),
        .i_value      (i_value),
        .i_busy_in    (i_busy_in),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_rs_out     (o_rs_out),
        .o_rw_out     (o_rw_out),
        .o_enable_out (o_enable_out),
        .o_bus_out    (o_bus_out),
        .o_bus_drive  (o_bus_drive),
        .o_ready_res  (o_ready_res),
        .o_rejected   (o_rejected)
    );

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // step through setup and hold phases that have already run their course
    function automatic void settle_phases();
        logic moved;
        moved = 1'b1;
        while (moved) begin
            moved = 1'b0;
            if (seq_phase == PH_SETUP && seq_count >= cfg_setup) begin
                seq_phase = PH_HOLD;
                seq_count = '0;
                moved     = 1'b1;
            end else if (seq_phase == PH_HOLD && seq_count >= cfg_hold) begin
                seq_count = '0;
                moved     = 1'b1;
                if (cfg_four && !second_half) begin
                    second_half = 1'b1;
                    seq_phase   = PH_SETUP;
                end else begin
                    seq_phase = PH_IDLE;
                end
            end
        end
    endfunction

    // pin levels after one word, advancing the sequencer state
    function automatic t_result predict_pins(t_word w);
        t_result r;
        logic    refused;
        refused = 1'b0;
        if (w.op == OP_REQ) begin
            if (seq_phase == PH_IDLE) begin
                held_byte   = w.val;
                held_sel    = w.sel;
                second_half = 1'b0;
                seq_count   = '0;
                seq_phase   = PH_POLL;
            end else begin
                refused = 1'b1;
            end
        end else if (seq_phase == PH_POLL) begin
            // panel reports ready when d7 reads low
            if (!w.busy) begin
                seq_phase = PH_SETUP;
                seq_count = '0;
                settle_phases();
            end
        end else if (seq_phase == PH_SETUP || seq_phase == PH_HOLD) begin
            if (seq_count != 8'hff) begin
                seq_count = seq_count + 8'd1;
            end
            settle_phases();
        end

        if (seq_phase == PH_POLL) begin
            r.rs    = 1'b0;
            r.rw    = 1'b1;
            r.en    = 1'b1;
            r.bus   = BUS_RELEASED;
            r.drive = 1'b0;
        end else begin
            r.rs    = held_sel;
            r.rw    = 1'b0;
            r.en    = (seq_phase == PH_HOLD);
            r.bus   = second_half ? {held_byte[3:0], 4'h0} : held_byte;
            r.drive = 1'b1;
        end
        r.ready_res = (seq_phase == PH_IDLE);
        r.rejected  = refused;
        return r;
    endfunction

    function automatic t_row word_row(t_op op, logic sel, logic [7:0] val, logic busy,
                                      logic typed = 1'b0, t_result want = '0);
        t_row r;
        r.kind   = ROW_WORD;
        r.w.op   = op;
        r.w.sel  = sel;
        r.w.val  = val;
        r.w.busy = busy;
        r.idx    = '0;
        r.data   = '0;
        r.typed  = typed;
        r.want   = want;
        return r;
    endfunction

    function automatic t_row cfg_row(logic [1:0] idx, logic [7:0] data);
        t_row r;
        r       = word_row(OP_TICK, 1'b0, 8'h00, 1'b0);
        r.kind  = ROW_CFG;
        r.idx   = idx;
        r.data  = data;
        return r;
    endfunction

    function automatic t_word random_word();
        t_word w;
        w.op   = ($urandom_range(0, 99) < 30) ? OP_REQ : OP_TICK;
        w.sel  = 1'($urandom_range(0, 1));
        w.val  = 8'($urandom_range(0, 255));
        w.busy = ($urandom_range(0, 3) == 0);
        return w;
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch at result %0d: %s", words_checked, msg);
        mismatch_count++;
    endtask

    task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %h expected %h", name, got, want));
        end
    endtask

    // present one word, wait for acceptance, queue its expected pins
    task automatic send_word(t_word w, logic typed, t_result literal);
        t_result want;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_kind    <= w.op;
        i_is_data <= w.sel;
        i_value   <= w.val;
        i_busy_in <= w.busy;
        do @(posedge i_clk); while (!o_ready);
        want = predict_pins(w);
        pin_levels_q.push_back(typed ? literal : want);
    endtask

    // hold the sender off until every expected word has come back
    task automatic wait_results_drained(int extra_cycles);
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pin_levels_q.size() != 0);
        repeat (extra_cycles) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [7:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_FOUR_BIT: cfg_four  = data[0];
            CFG_SETUP:    cfg_setup = data;
            CFG_HOLD:     cfg_hold  = data;
            default:      ;
        endcase
        @(posedge i_clk);
    endtask

    // receiver stalls
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // result checker
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            got = '{rs: o_rs_out, rw: o_rw_out, en: o_enable_out, bus: o_bus_out,
                    drive: o_bus_drive, ready_res: o_ready_res, rejected: o_rejected};
            if (pin_levels_q.size() == 0) begin
                report_mismatch($sformatf("unexpected word %h", got));
            end else begin
                want = pin_levels_q.pop_front();
                check_field("rs", 8'(got.rs), 8'(want.rs));
                check_field("rw", 8'(got.rw), 8'(want.rw));
                check_field("enable", 8'(got.en), 8'(want.en));
                check_field("bus", got.bus, want.bus);
                check_field("bus_drive", 8'(got.drive), 8'(want.drive));
                check_field("ready_res", 8'(got.ready_res), 8'(want.ready_res));
                check_field("rejected", 8'(got.rejected), 8'(want.rejected));
            end
            words_checked++;
        end
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial begin
        wait (stuck_cycles >= STUCK_LIMIT);
        $display("char_lcd_write_sequencer test failed");
        $finish;
    end

    // stimulus
    initial begin
        // reset state, a full write and a refused request
        stim_rows.push_back(word_row(OP_TICK, 1'b0, 8'h00, 1'b0, 1'b1, PINS_AT_RESET));
        stim_rows.push_back(word_row(OP_REQ, 1'b1, 8'hff, 1'b1, 1'b1, PINS_POLLING));
        stim_rows.push_back(word_row(OP_REQ, 1'b0, 8'h00, 1'b0, 1'b1, PINS_POLL_REFUSED));
        stim_rows.push_back(word_row(OP_TICK, 1'b0, 8'h00, 1'b1, 1'b1, PINS_POLLING));
        repeat (7) stim_rows.push_back(word_row(OP_TICK, 1'b1, 8'h81, 1'b0));
        // zero setup and hold in four-bit mode finish in one tick
        stim_rows.push_back(cfg_row(CFG_FOUR_BIT, 8'h01));
        stim_rows.push_back(cfg_row(CFG_SETUP, 8'h00));
        stim_rows.push_back(cfg_row(CFG_HOLD, 8'h00));
        stim_rows.push_back(word_row(OP_REQ, 1'b0, 8'h5a, 1'b0));
        stim_rows.push_back(word_row(OP_TICK, 1'b0, 8'h00, 1'b0));
        // two nibble pulses with a request refused during setup
        stim_rows.push_back(cfg_row(CFG_SETUP, 8'h02));
        stim_rows.push_back(cfg_row(CFG_HOLD, 8'h01));
        stim_rows.push_back(word_row(OP_REQ, 1'b1, 8'hc3, 1'b0));
        stim_rows.push_back(word_row(OP_TICK, 1'b0, 8'h00, 1'b0));
        stim_rows.push_back(word_row(OP_TICK, 1'b0, 8'h00, 1'b0));
        stim_rows.push_back(word_row(OP_REQ, 1'b1, 8'h00, 1'b0));
        repeat (5) stim_rows.push_back(word_row(OP_TICK, 1'b0, 8'h7e, 1'b1));
        // index past the last register is ignored
        stim_rows.push_back(cfg_row(2'd3, 8'hff));
        stim_rows.push_back(word_row(OP_TICK, 1'b0, 8'h00, 1'b0));

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        foreach (stim_rows[n]) begin
            if (stim_rows[n].kind == ROW_CFG) begin
                wait_results_drained(SETTLE_CYCLES);
                write_reg(stim_rows[n].idx, stim_rows[n].data);
            end else begin
                send_word(stim_rows[n].w, stim_rows[n].typed, stim_rows[n].want);
            end
        end

        // random phases, each with its own register setting and idling
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            logic       four;
            logic [7:0] setup;
            logic [7:0] hold;
            case (p)
                0: begin four = 1'b0; setup = 8'd0;   hold = 8'd0;   end
                1: begin four = 1'b1; setup = 8'd1;   hold = 8'd5;   end
                2: begin four = 1'b1; setup = 8'd255; hold = 8'd0;   end
                3: begin four = 1'b0; setup = 8'd3;   hold = 8'd255; end
                default: begin
                    four  = 1'($urandom_range(0, 1));
                    setup = 8'($urandom_range(0, 4));
                    hold  = 8'($urandom_range(0, 4));
                end
            endcase
            case (p % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 74; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 74; end
                default: begin src_idle_pct = 38; sink_stall_pct = 38; end
            endcase
            wait_results_drained(SETTLE_CYCLES);
            write_reg(CFG_FOUR_BIT, {7'd0, four});
            write_reg(CFG_SETUP, setup);
            write_reg(CFG_HOLD, hold);
            repeat (WORDS_PER_PHASE) begin
                if ($urandom_range(0, 29) == 0) begin
                    wait_results_drained(0);
                end
                send_word(random_word(), 1'b0, '0);
            end
        end

        wait_results_drained(8);
        if (mismatch_count == 0) begin
            $display("char_lcd_write_sequencer test passed");
        end else begin
            $display("char_lcd_write_sequencer test failed");
        end
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/lcdws_pkg.sv
hw/rtl/lcdws_front.sv
hw/rtl/lcdws_queue.sv
hw/rtl/lcdws_back.sv
hw/rtl/char_lcd_write_sequencer.sv
hw/rtl/lcdws_checker.sv
dv/tb_top.sv
